### rtl/core/mpq_pkg.sv
package mpq_pkg;

    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CHW    = AW + 2;
    localparam int KW     = 32;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int STS_W  = 3;

    typedef logic signed [KW-1:0] t_key;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_EXTRACT  = 2'd1,
        FUNC_INCREASE = 2'd2,
        FUNC_PEEK     = 2'd3
    } t_func;

    typedef enum logic [STS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_BADIDX  = 3'd3,
        ST_SMALLER = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INC_CMP,
        S_EX_LD,
        S_UP_WR,
        S_UP_CMP,
        S_DN_RL,
        S_DN_LC,
        S_DN_RC,
        S_DN_SW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    ins_start;
        logic    ex_start;
        logic    ex_load;
        logic    inc_rd;
        logic    up_wr;
        logic    up_move;
        logic    dn_rl;
        logic    dn_lc;
        logic    dn_rc;
        logic    dn_sw;
        logic    dn_fin;
        logic    st_set;
        t_status st_code;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  cnt_zero;
        logic  full;
        logic  idx_bad;
        logic  inc_smaller;
        logic  pos_root;
        logic  up_gt;
        logic  lc_ok;
        logic  rc_ok;
        logic  best_is_pos;
    } t_dp_sts;

endpackage

### rtl/core/mpq_ram.sv
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mpq_datapath.sv
module mpq_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpq_pkg::t_func            i_in_func,
    input  mpq_pkg::t_key             i_in_key,
    input  logic [mpq_pkg::IDX_W-1:0] i_in_idx,
    input  mpq_pkg::t_dp_cmd          i_cmd,
    output mpq_pkg::t_dp_sts          o_sts,
    output mpq_pkg::t_key             o_top_key,
    output mpq_pkg::t_key             o_removed_key,
    output logic [mpq_pkg::CNT_W-1:0] o_entry_count,
    output mpq_pkg::t_status          o_status
);

    import mpq_pkg::*;

    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    t_func          r_func;
    t_key           r_key;
    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  r_pos;
    logic [AW-1:0]  r_best;
    t_key           r_best_key;
    t_key           r_top;
    t_key           r_removed;
    t_status        r_st;
    t_key           r_o_top;
    t_key           r_o_removed;
    logic [CW-1:0]  r_o_cnt;
    t_status        r_o_st;

    logic [CW-1:0]  cnt_dec;
    logic [AW-1:0]  parent;
    logic [CHW-1:0] lc;
    logic [CHW-1:0] rc;
    logic           lc_gt;
    logic           rc_gt;
    logic           we;
    logic [AW-1:0]  raddr;
    t_key           wdata;
    t_key           rdata;
    logic [KW-1:0]  rdata_raw;

    assign cnt_dec = r_cnt - CW'(1);
    assign parent  = (r_pos - AW'(1)) >> 1;
    assign lc      = CHW'({r_pos, 1'b1});
    assign rc      = CHW'({r_pos, 1'b0}) + CHW'(2);
    assign rdata   = t_key'(rdata_raw);
    assign lc_gt   = rdata > r_key;
    assign rc_gt   = rdata > r_best_key;

    assign we = i_cmd.up_wr | i_cmd.up_move | i_cmd.dn_fin | i_cmd.dn_sw;

    always_comb begin
        priority if (i_cmd.up_move) begin
            wdata = rdata;
        end else if (i_cmd.dn_sw) begin
            wdata = r_best_key;
        end else begin
            wdata = r_key;
        end
    end

    always_comb begin
        priority if (i_cmd.ex_start) begin
            raddr = cnt_dec[AW-1:0];
        end else if (i_cmd.inc_rd) begin
            raddr = r_idx;
        end else if (i_cmd.up_wr) begin
            raddr = parent;
        end else if (i_cmd.dn_rl) begin
            raddr = lc[AW-1:0];
        end else if (i_cmd.dn_lc) begin
            raddr = rc[AW-1:0];
        end else begin
            raddr = '0;
        end
    end

    mpq_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        priority if (i_cmd.ins_start) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.ex_start) begin
            n_cnt = cnt_dec;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_in_func;
            r_key     <= i_in_key;
            r_idx     <= i_in_idx;
            r_removed <= '0;
            r_st      <= ST_OK;
        end
        if (i_cmd.st_set) begin
            r_st <= i_cmd.st_code;
        end
        if (i_cmd.ex_start) begin
            r_removed <= r_top;
        end
        if (i_cmd.ex_load) begin
            r_key <= rdata;
        end
        priority if (i_cmd.ins_start) begin
            r_pos <= r_cnt[AW-1:0];
        end else if (i_cmd.inc_rd) begin
            r_pos <= r_idx;
        end else if (i_cmd.ex_load) begin
            r_pos <= '0;
        end else if (i_cmd.up_move) begin
            r_pos <= parent;
        end else if (i_cmd.dn_sw) begin
            r_pos <= r_best;
        end
        if (i_cmd.dn_lc) begin
            r_best     <= lc_gt ? lc[AW-1:0] : r_pos;
            r_best_key <= lc_gt ? rdata : r_key;
        end
        if (i_cmd.dn_rc && rc_gt) begin
            r_best     <= rc[AW-1:0];
            r_best_key <= rdata;
        end
        if (we && r_pos == '0) begin
            r_top <= wdata;
        end
        if (i_cmd.out_load) begin
            r_o_top     <= (r_cnt != '0) ? r_top : '0;
            r_o_removed <= r_removed;
            r_o_cnt     <= r_cnt;
            r_o_st      <= r_st;
        end
    end

    always_comb begin
        o_sts.func        = r_func;
        o_sts.cnt_zero    = r_cnt == '0;
        o_sts.full        = r_cnt == CW'(DEPTH);
        o_sts.idx_bad     = CW'(r_idx) >= r_cnt;
        o_sts.inc_smaller = rdata > r_key;
        o_sts.pos_root    = r_pos == '0;
        o_sts.up_gt       = r_key > rdata;
        o_sts.lc_ok       = lc < CHW'(r_cnt);
        o_sts.rc_ok       = rc < CHW'(r_cnt);
        o_sts.best_is_pos = r_best == r_pos;
    end

    assign o_top_key     = r_o_top;
    assign o_removed_key = r_o_removed;
    assign o_entry_count = CNT_W'(r_o_cnt);
    assign o_status      = r_o_st;

endmodule

### rtl/core/mpq_ctrl.sv
module mpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  mpq_pkg::t_dp_sts i_sts,
    output mpq_pkg::t_dp_cmd o_cmd
);

    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FUNC_INSERT:   n_state = i_sts.full ? S_DONE : S_UP_WR;
                    FUNC_EXTRACT:  n_state = i_sts.cnt_zero ? S_DONE : S_EX_LD;
                    FUNC_INCREASE: n_state = i_sts.idx_bad ? S_DONE : S_INC_CMP;
                    FUNC_PEEK:     n_state = S_DONE;
                    default:       n_state = S_DONE;
                endcase
            end
            S_INC_CMP: n_state = i_sts.inc_smaller ? S_DONE : S_UP_WR;
            S_EX_LD:   n_state = S_DN_RL;
            S_UP_WR:   n_state = i_sts.pos_root ? S_DONE : S_UP_CMP;
            S_UP_CMP:  n_state = i_sts.up_gt ? S_UP_WR : S_DONE;
            S_DN_RL:   n_state = i_sts.lc_ok ? S_DN_LC : S_DONE;
            S_DN_LC:   n_state = i_sts.rc_ok ? S_DN_RC : S_DN_SW;
            S_DN_RC:   n_state = S_DN_SW;
            S_DN_SW:   n_state = i_sts.best_is_pos ? S_DONE : S_DN_RL;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.st_code = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_s_tvalid;
            end
            S_DECODE: begin
                unique case (i_sts.func)
                    FUNC_INSERT: begin
                        o_cmd.st_set    = i_sts.full;
                        o_cmd.st_code   = ST_FULL;
                        o_cmd.ins_start = !i_sts.full;
                    end
                    FUNC_EXTRACT: begin
                        o_cmd.st_set   = i_sts.cnt_zero;
                        o_cmd.st_code  = ST_EMPTY;
                        o_cmd.ex_start = !i_sts.cnt_zero;
                    end
                    FUNC_INCREASE: begin
                        o_cmd.st_set  = i_sts.idx_bad;
                        o_cmd.st_code = ST_BADIDX;
                        o_cmd.inc_rd  = !i_sts.idx_bad;
                    end
                    FUNC_PEEK: begin
                        o_cmd.st_set  = i_sts.cnt_zero;
                        o_cmd.st_code = ST_EMPTY;
                    end
                    default: begin
                        o_cmd.st_set = 1'b0;
                    end
                endcase
            end
            S_INC_CMP: begin
                o_cmd.st_set  = i_sts.inc_smaller;
                o_cmd.st_code = ST_SMALLER;
            end
            S_EX_LD:  o_cmd.ex_load = 1'b1;
            S_UP_WR:  o_cmd.up_wr = 1'b1;
            S_UP_CMP: o_cmd.up_move = i_sts.up_gt;
            S_DN_RL: begin
                o_cmd.dn_rl  = i_sts.lc_ok;
                o_cmd.dn_fin = !i_sts.lc_ok;
            end
            S_DN_LC: o_cmd.dn_lc = 1'b1;
            S_DN_RC: o_cmd.dn_rc = 1'b1;
            S_DN_SW: begin
                o_cmd.dn_sw  = !i_sts.best_is_pos;
                o_cmd.dn_fin = i_sts.best_is_pos;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.accept = 1'b0;
            end
        endcase
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_valid;

endmodule

### rtl/core/max_priority_queue_unit.sv
// Binary max-heap of up to 64 signed 32-bit keys, one operation per input item
// (insert, extract max, increase key, peek) and exactly one result item per input.
// Items are handled one at a time. A peek or an operation refused at decode ends
// there, and an increase with a smaller key ends once its old key is compared.
// An insert writes its key and moves it up a level at a time until it reaches the
// root or stops below a parent that is not smaller; an increase whose key is taken
// does the same from its index. An extract moves the last key to the root and sinks
// it a level at a time, reading the left and then the right child, with no right
// read wherever a node has no right child, until it ends on a leaf or stops above
// its children. The heap RAM has one registered read port and one write port, so
// keys are read one at a time. The next item is taken while the last result still
// waits on the output register, and a finished result that cannot be loaded holds
// the block until that register frees.
module max_priority_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // key_value, entry_index, zero fill
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // top_key, removed_key, entry_count, zero fill
    output logic [2:0]  m_axis_tuser    // status
);

    import mpq_pkg::*;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    t_key               top_key;
    t_key               removed_key;
    logic [CNT_W-1:0]   entry_count;
    t_status            status;

    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mpq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_func     (t_func'(s_axis_tuser)),
        .i_in_key      (t_key'(s_axis_tdata[KW-1:0])),
        .i_in_idx      (s_axis_tdata[KW+IDX_W-1:KW]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_top_key     (top_key),
        .o_removed_key (removed_key),
        .o_entry_count (entry_count),
        .o_status      (status)
    );

    assign m_axis_tdata = {1'b0, entry_count, removed_key, top_key};
    assign m_axis_tuser = status;

endmodule

### sim/heap_result_checker.sv
module heap_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,    // key_value, entry_index, zero fill
    input  logic [1:0]  i_in_user,    // func
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,   // top_key, removed_key, entry_count, zero fill
    input  logic [2:0]  i_out_user,   // status
    output int          o_fail_count,
    output int          o_pending
);

    import mpq_pkg::*;

    typedef struct packed {
        t_key             top;
        t_key             removed;
        logic [CNT_W-1:0] count;
        t_status          status;
    } t_heap_result;

    t_key         heap_keys [DEPTH];
    int           held;
    t_heap_result results_due [$];
    int           mismatches = 0;
    int           result_num = 0;

    assign o_fail_count = mismatches;

    function automatic void sift_key_up(input int start, input t_key key);
        int pos;
        int up;
        pos = start;
        heap_keys[pos] = key;
        while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!(key > heap_keys[up]))
                break;
            heap_keys[pos] = heap_keys[up];
            heap_keys[up] = key;
            pos = up;
        end
    endfunction

    function automatic t_heap_result run_heap_op(input t_func op, input t_key key,
                                                 input logic [IDX_W-1:0] idx);
        t_heap_result r;
        int           pos;
        int           best;
        int           lc;
        int           rc;
        t_key         tmp;
        r.removed = '0;
        r.status  = ST_OK;
        case (op)
            FUNC_INSERT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held++;
                    sift_key_up(held - 1, key);
                end
            end
            FUNC_EXTRACT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = heap_keys[0];
                    held--;
                    heap_keys[0] = heap_keys[held];
                    pos = 0;
                    // On equal children the left one is taken.
                    while (1) begin
                        best = pos;
                        lc = 2 * pos + 1;
                        rc = 2 * pos + 2;
                        if (lc < held && heap_keys[lc] > heap_keys[best])
                            best = lc;
                        if (rc < held && heap_keys[rc] > heap_keys[best])
                            best = rc;
                        if (best == pos)
                            break;
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[best];
                        heap_keys[best] = tmp;
                        pos = best;
                    end
                end
            end
            FUNC_INCREASE: begin
                if (int'(idx) >= held)
                    r.status = ST_BADIDX;
                else if (heap_keys[idx] > key)
                    r.status = ST_SMALLER;
                else
                    sift_key_up(int'(idx), key);
            end
            default: begin
                if (held == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        r.top   = (held > 0) ? heap_keys[0] : '0;
        r.count = CNT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result want;
        t_heap_result got;
        if (!i_rst_n) begin
            held = 0;
            for (int i = 0; i < DEPTH; i++)
                heap_keys[i] = '0;
            results_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                want = run_heap_op(t_func'(i_in_user), t_key'(i_in_data[31:0]),
                                   i_in_data[37:32]);
                results_due.insert(results_due.size(), want);
            end
            if (i_out_valid && i_out_ready) begin
                got.top     = t_key'(i_out_data[31:0]);
                got.removed = t_key'(i_out_data[63:32]);
                got.count   = i_out_data[70:64];
                got.status  = t_status'(i_out_user);
                if (results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("Result %0d arrived with no item waiting for it: top %0d",
                                 result_num, got.top);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got.top !== want.top || got.removed !== want.removed ||
                        got.count !== want.count || got.status !== want.status) begin
                        if (mismatches < 10) begin
                            $display(
                                "Result %0d: expected top %0d removed %0d count %0d status %0d",
                                result_num, want.top, want.removed, want.count,
                                want.status);
                            $display(
                                "Result %0d: got top %0d removed %0d count %0d status %0d",
                                result_num, got.top, got.removed, got.count,
                                got.status);
                        end
                        mismatches++;
                    end
                end
                result_num++;
            end
        end
        o_pending <= results_due.size();
    end

endmodule

### sim/testbench.sv
module testbench;
    import mpq_pkg::*;

    localparam t_key KEY_MAX = 32'h7fff_ffff;
    localparam t_key KEY_MIN = 32'h8000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // key_value, entry_index, zero fill
    logic [1:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // top_key, removed_key, entry_count, zero fill
    logic [2:0]  m_axis_tuser;        // status

    int fail_count;
    int results_due;
    int send_idle_pct = 6;
    int recv_idle_pct = 79;
    int held_guess = 0;
    int op_tally [4] = '{default: 0};
    int full_refusals = 0;
    int empty_extracts = 0;
    int times_full = 0;

    max_priority_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    heap_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_op(input t_func op, input t_key key, input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, idx, key};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        op_tally[op]++;
        if (op == FUNC_INSERT) begin
            if (held_guess == DEPTH) begin
                full_refusals++;
            end else begin
                held_guess++;
                if (held_guess == DEPTH)
                    times_full++;
            end
        end else if (op == FUNC_EXTRACT) begin
            if (held_guess == 0)
                empty_extracts++;
            else
                held_guess--;
        end
    endtask

    task automatic wait_for_results();
        if (results_due != 0) begin
            s_axis_tvalid = 1'b0;
            while (results_due != 0)
                @(negedge i_clk);
        end
    endtask

    function automatic t_key pick_key();
        case ($urandom_range(9))
            0, 1, 2, 3: return t_key'($urandom);
            4, 5, 6:    return t_key'(int'($urandom_range(15)) - 8);
            7: begin
                case ($urandom_range(3))
                    0:       return KEY_MAX;
                    1:       return KEY_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:    return t_key'(int'($urandom_range(1000)) - 500);
        endcase
    endfunction

    // Alternates between filling the heap to full and draining it to empty,
    // with a share of operations that go against the current direction.
    task automatic run_random_phase(input int n_items);
        bit               draining;
        int               r;
        t_func            op;
        t_key             key;
        logic [IDX_W-1:0] idx;
        draining = (held_guess > DEPTH / 2);
        repeat (n_items) begin
            if (!draining && held_guess == DEPTH && $urandom_range(3) == 0)
                draining = 1'b1;
            else if (draining && held_guess == 0 && $urandom_range(3) == 0)
                draining = 1'b0;
            r = $urandom_range(99);
            if (r < 8)
                op = t_func'($urandom_range(3));
            else if (r < 60)
                op = draining ? FUNC_EXTRACT : FUNC_INSERT;
            else if (r < 72)
                op = draining ? FUNC_INSERT : FUNC_EXTRACT;
            else if (r < 92)
                op = FUNC_INCREASE;
            else
                op = FUNC_PEEK;
            key = pick_key();
            if (op == FUNC_INCREASE && $urandom_range(2) == 0)
                key = t_key'(32'h4000_0000 + $urandom_range(32'h3fff_ffff));
            if (op == FUNC_INCREASE && held_guess > 0 && $urandom_range(4) != 0)
                idx = IDX_W'($urandom_range(held_guess - 1));
            else
                idx = IDX_W'($urandom_range(63));
            if ($urandom_range(149) == 0)
                wait_for_results();
            send_op(op, key, idx);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty heap: peek, extract and increase are all refused.
        send_op(FUNC_PEEK, '0, '0);
        send_op(FUNC_EXTRACT, '0, '0);
        send_op(FUNC_INCREASE, KEY_MAX, '0);
        send_op(FUNC_INSERT, '0, '0);
        send_op(FUNC_INSERT, KEY_MAX, 6'h3f);
        send_op(FUNC_INSERT, KEY_MIN, '0);
        send_op(FUNC_INSERT, '1, '0);
        send_op(FUNC_INSERT, 32'sd5, '0);
        send_op(FUNC_INSERT, 32'sd5, '0);
        send_op(FUNC_PEEK, '0, '0);
        // Position 3 holds -1: a smaller key is refused, an equal one taken.
        send_op(FUNC_INCREASE, KEY_MIN, 6'd3);
        send_op(FUNC_INCREASE, '1, 6'd3);
        send_op(FUNC_INCREASE, KEY_MAX, 6'd5);
        send_op(FUNC_INCREASE, KEY_MAX, 6'd6);
        send_op(FUNC_INCREASE, KEY_MAX, 6'h3f);
        repeat (7) send_op(FUNC_EXTRACT, '0, '0);
        send_op(FUNC_PEEK, '0, '0);
        wait_for_results();

        run_random_phase(360);
        wait_for_results();
        send_idle_pct = 79;
        recv_idle_pct = 6;
        run_random_phase(360);
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(360);

        s_axis_tvalid = 1'b0;
        while (results_due != 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Sent %0d inserts, %0d extracts, %0d increases and %0d peeks.",
                 op_tally[FUNC_INSERT], op_tally[FUNC_EXTRACT], op_tally[FUNC_INCREASE],
                 op_tally[FUNC_PEEK]);
        $display("The heap was full %0d times; %0d inserts and %0d extracts were refused.",
                 times_full, full_refusals, empty_extracts);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/core/mpq_pkg.sv
rtl/core/mpq_ram.sv
rtl/core/mpq_datapath.sv
rtl/core/mpq_ctrl.sv
rtl/core/max_priority_queue_unit.sv
sim/heap_result_checker.sv
sim/testbench.sv
